// ===== rtl/prtl_pkg.sv =====
// shared types, codes and helpers for the prefix route table
package prtl_pkg;

   localparam int ENTRIES_DEFAULT = 64;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int LIFE_W   = 16;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [7:0] MIN_LEN = 8'd8;
   localparam logic [7:0] MAX_LEN = 8'd32;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_ADD       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DEL_EXACT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DEL_COVER = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FIND      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   // transaction as it travels down the cell chain
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   network;
      logic [LEN_W-1:0]    len;
      logic [LIFE_W-1:0]   life;
      logic [LEN_W-1:0]    best;
      logic                placed;
      logic                invalid;
   } wave_type;

   // top len bits set; all ones for 32 and above, zero for 0
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      return ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

// ===== rtl/prtl_cell.sv =====
// one table slot with its stage of the transaction chain
module prtl_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               wave_valid_in,
   input  prtl_pkg::wave_type wave_in,
   output logic               wave_valid_ff,
   output prtl_pkg::wave_type wave_ff
);

   logic                          slot_valid_ff, slot_valid_in;
   logic [prtl_pkg::ADDR_W-1:0]   slot_network_ff, slot_network_in;
   logic [prtl_pkg::LEN_W-1:0]    slot_length_ff, slot_length_in;
   logic [prtl_pkg::LIFE_W-1:0]   slot_countdown_ff, slot_countdown_in;
   prtl_pkg::wave_type            wave_in_next;
   logic                          covers;

   assign covers = slot_valid_ff &&
      ((wave_in.address & prtl_pkg::len_mask(slot_length_ff)) == slot_network_ff);

   always_comb begin
      slot_valid_in     = slot_valid_ff;
      slot_network_in   = slot_network_ff;
      slot_length_in    = slot_length_ff;
      slot_countdown_in = slot_countdown_ff;
      wave_in_next      = wave_in;
      if (wave_valid_in) begin
         unique case (wave_in.action)
            prtl_pkg::ACT_ADD: begin
               if (!wave_in.invalid && !wave_in.placed && !slot_valid_ff) begin
                  slot_valid_in       = 1'b1;
                  slot_network_in     = wave_in.network;
                  slot_length_in      = wave_in.len;
                  slot_countdown_in   = wave_in.life;
                  wave_in_next.placed = 1'b1;
               end
            end
            prtl_pkg::ACT_DEL_EXACT: begin
               if (!wave_in.invalid && slot_valid_ff && slot_length_ff == wave_in.len &&
                   slot_network_ff == wave_in.network) begin
                  slot_valid_in = 1'b0;
               end
            end
            prtl_pkg::ACT_DEL_COVER: begin
               if (covers) begin
                  slot_valid_in = 1'b0;
               end
            end
            prtl_pkg::ACT_FIND: begin
               if (covers && slot_length_ff > wave_in.best) begin
                  wave_in_next.best = slot_length_ff;
               end
            end
            prtl_pkg::ACT_TICK: begin
               if (slot_valid_ff && slot_countdown_ff != '0) begin
                  slot_countdown_in = slot_countdown_ff - 1'b1;
                  if (slot_countdown_ff == prtl_pkg::LIFE_W'(1)) begin
                     slot_valid_in = 1'b0;
                  end
               end
            end
            prtl_pkg::ACT_CLEAR: begin
               slot_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         wave_valid_ff <= 1'b0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
         wave_valid_ff <= wave_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_network_ff   <= slot_network_in;
         slot_length_ff    <= slot_length_in;
         slot_countdown_ff <= slot_countdown_in;
         wave_ff           <= wave_in_next;
      end
   end

endmodule

// ===== rtl/prefix_route_table_lookup.sv =====
// top level of the ipv4 longest prefix match table built as a chain of slot cells
//
// usage
//   req_* carries one transaction: action, address, prefix_len, lifetime_secs.
//   it is taken at a clock edge where req_valid is high and req_stall is low.
//   rsp_* returns exactly one status / match_len per transaction, in order,
//   taken at an edge where rsp_valid is high and rsp_stall is low.
//   each transaction walks the row of ENTRIES cells, one cell per cycle unless
//   rsp_stall holds the chain; every cell owns one table slot and applies the
//   action to it as the transaction passes, carrying the best match and the
//   slot-taken flag along.
//   throughput: one transaction per cycle unless stalled; transactions follow each other down
//   the chain, so every slot sees them in acceptance order.
//   the chain length, one register stage per slot, sets the latency.
//   rsp_stall while rsp_valid is high freezes the whole chain and raises
//   req_stall in the same cycle; the presented result holds until taken.
//   reset clears every slot valid bit and the chain valid bits; no sweep.
module prefix_route_table_lookup #(
   parameter int ENTRIES = prtl_pkg::ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [prtl_pkg::ACTION_W-1:0]   req_action,
   input  logic [prtl_pkg::ADDR_W-1:0]     req_address,
   input  logic [7:0]                      req_prefix_len,
   input  logic [prtl_pkg::LIFE_W-1:0]     req_lifetime_secs,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [prtl_pkg::STATUS_W-1:0]   rsp_status,
   output logic [prtl_pkg::LEN_W-1:0]      rsp_match_len
);

   // whole chain moves together; it only waits on a stalled result
   logic                        advance;
   logic [ENTRIES:0]            wave_valid;
   prtl_pkg::wave_type          wave [ENTRIES+1];
   prtl_pkg::wave_type          head_wave;
   logic                        len_bad;
   logic                        len_checked;
   prtl_pkg::wave_type          last_wave;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // length check only matters for add and exact delete
   assign len_checked = (req_action == prtl_pkg::ACT_ADD) ||
                        (req_action == prtl_pkg::ACT_DEL_EXACT);
   assign len_bad     = (req_prefix_len < prtl_pkg::MIN_LEN) ||
                        (req_prefix_len > prtl_pkg::MAX_LEN);

   // head of the chain: build the transaction entering the first cell
   always_comb begin
      head_wave.action  = req_action;
      head_wave.address = req_address;
      head_wave.len     = req_prefix_len[prtl_pkg::LEN_W-1:0];
      // masked network for add / exact delete
      head_wave.network = req_address &
                          prtl_pkg::len_mask(req_prefix_len[prtl_pkg::LEN_W-1:0]);
      head_wave.life    = req_lifetime_secs;
      head_wave.best    = '0;
      head_wave.placed  = 1'b0;
      head_wave.invalid = len_checked && len_bad;
   end

   assign wave_valid[0] = req_valid;
   assign wave[0]       = head_wave;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      prtl_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .wave_valid_in (wave_valid[i]),
         .wave_in       (wave[i]),
         .wave_valid_ff (wave_valid[i+1]),
         .wave_ff       (wave[i+1])
      );
   end

   // the last cell's stage register is the result register
   assign last_wave = wave[ENTRIES];
   assign rsp_valid = wave_valid[ENTRIES];

   always_comb begin
      priority if (last_wave.invalid) begin
         rsp_status = prtl_pkg::STATUS_INVALID;
      end else if (last_wave.action == prtl_pkg::ACT_ADD && !last_wave.placed) begin
         // no free slot anywhere along the chain
         rsp_status = prtl_pkg::STATUS_FULL;
      end else begin
         rsp_status = prtl_pkg::STATUS_OK;
      end
   end

   assign rsp_match_len = last_wave.best;

   // a stalled result must hold the request side
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("result stalled but request side open");

   // a match length only comes from a find
   a_match_only_find: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_len != '0 |-> last_wave.action == prtl_pkg::ACT_FIND)
      else $error("match length on a non-find transaction");

   // longest prefix never exceeds 32
   a_match_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_match_len <= prtl_pkg::LEN_W'(32))
      else $error("match length out of range");

   // table full is only reported for a well formed add
   a_full_only_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == prtl_pkg::STATUS_FULL |->
         last_wave.action == prtl_pkg::ACT_ADD && !last_wave.invalid)
      else $error("table full on a non-add transaction");

   // chain is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
